// ===== rtl/tcrc_pkg.sv =====
`timescale 1ns / 1ps
package tcrc_pkg;

  localparam int NUM_TIMERS = 3;
  localparam int NUM_W = 25;     // serial dividend width (17-bit sum shifted by 8)
  localparam int DEN_W = 16;
  localparam int CNT_W = 5;

  localparam logic [1:0] CMD_ADVANCE = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [3:0] OFF_COUNT  = 4'd0;
  localparam logic [3:0] OFF_MODE   = 4'd4;
  localparam logic [3:0] OFF_TARGET = 4'd8;

  localparam logic [1:0] CFG_ALT0 = 2'd0;
  localparam logic [1:0] CFG_ALT1 = 2'd1;
  localparam logic [1:0] CFG_ALT2 = 2'd2;

  localparam logic [15:0] MODE_RESET   = 16'h0400;
  localparam logic [15:0] ALT_RESET    = 16'd256;
  localparam logic [15:0] MIN_ALT_RATE = 16'd256;
  localparam logic [17:0] BOUND_VALUE  = 18'h0ffff;

  localparam int MB_RST_TGT = 3;
  localparam int MB_IRQ_TGT = 4;
  localparam int MB_IRQ_BND = 5;
  localparam int MB_REPEAT  = 6;
  localparam int MB_TOGGLE  = 7;
  localparam int MB_SRC01   = 8;
  localparam int MB_SRC2    = 9;
  localparam int MB_REQUEST = 10;
  localparam int MB_HIT_TGT = 11;
  localparam int MB_HIT_BND = 12;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  reg_address;
    logic [15:0] write_value;
    logic [15:0] tick_count;
  } req_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic [2:0]  irq_raised;
  } rsp_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num_a;
    logic [DEN_W-1:0] den_a;
    logic [NUM_W-1:0] num_b;
    logic [DEN_W-1:0] den_b;
  } div_req_t;

  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] quo_a;
    logic [DEN_W-1:0] rem_b;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOAD  = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_APPLY = 4'b1000
  } state_t;

endpackage

// ===== rtl/tcrc_div.sv =====
`timescale 1ns / 1ps
// Two restoring dividers stepping in lockstep, one quotient bit per cycle.
module tcrc_div
  import tcrc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [NUM_W-1:0] na;
  logic [NUM_W-1:0] nb;
  logic [DEN_W-1:0] ra;
  logic [DEN_W-1:0] rb;
  logic [DEN_W-1:0] da;
  logic [DEN_W-1:0] db;
  logic [CNT_W-1:0] cnt;
  logic             vld;

  logic [DEN_W:0] ra_sh;
  logic [DEN_W:0] rb_sh;
  logic           qa;
  logic           qb;
  logic [DEN_W:0] ra_next;
  logic [DEN_W:0] rb_next;

  always_comb begin
    ra_sh = {ra, na[NUM_W-1]};
    rb_sh = {rb, nb[NUM_W-1]};
    qa = (ra_sh >= {1'b0, da});
    qb = (rb_sh >= {1'b0, db});
    ra_next = qa ? (ra_sh - {1'b0, da}) : ra_sh;
    rb_next = qb ? (rb_sh - {1'b0, db}) : rb_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      vld <= 1'b0;
    end else begin
      vld <= 1'b0;
      if (req.start) begin
        cnt <= CNT_W'(NUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          vld <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      na <= req.num_a;
      nb <= req.num_b;
      da <= req.den_a;
      db <= req.den_b;
      ra <= '0;
      rb <= '0;
    end else if (cnt != '0) begin
      // quotient bits shift into the vacated low end of the dividend
      na <= {na[NUM_W-2:0], qa};
      nb <= {nb[NUM_W-2:0], qb};
      ra <= ra_next[DEN_W-1:0];
      rb <= rb_next[DEN_W-1:0];
    end
  end

  assign rsp.valid = vld;
  assign rsp.quo_a = na;
  assign rsp.rem_b = rb;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> cnt == '0)
    else $error("divider restarted while running");

  a_valid_after_last: assert property (@(posedge clk) disable iff (rst)
    vld |-> $past(cnt) == CNT_W'(1))
    else $error("divider result without final step");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(NUM_W))
    else $error("divider step count out of range");

endmodule

// ===== rtl/three_channel_root_counter.sv =====
`timescale 1ns / 1ps
// Three 16-bit root counters behind a register window.
// Command channel: a transaction is taken when start is high and busy is low.
// request.cmd selects advance time, register write or register read;
// request.reg_address bits 5:4 pick the timer, bits 3:0 the register.
// Every transaction gives one result: done is high for one cycle with
// result.read_value and result.irq_raised on the result port.
// Reads and writes leave busy low; done is high in the cycle after
// acceptance.
// An advance transaction runs the three timers one after another through
// one shared bit-serial divider: per timer a load (ST_LOAD), a divide
// (ST_WAIT, until the divider result is valid) and an update (ST_APPLY)
// step. busy is high from acceptance until done.
// The 25-bit serial dividend (tick sum scaled by 256 for alternate rates, else by 2) sets the divide length.
// Alternate rates sit on the APB port at byte addresses 0, 4 and 8.
// Synchronous reset: counts, targets and remainders zero, mode words 0x0400,
// alternate rates 256. The receiver cannot stall: each result is presented
// exactly once.
module three_channel_root_counter
  import tcrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  req_t        request,
  output logic        busy,
  output logic        done,
  output rsp_t        result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef struct packed {
    logic [15:0] mode;
    logic        oneshot;
    logic        irq;
  } irq_upd_t;

  state_t      state;
  logic [1:0]  tsel;
  logic [15:0] ticks;
  logic [15:0] alt_rate [NUM_TIMERS];
  logic [15:0] count_value [NUM_TIMERS];
  logic [15:0] mode_word [NUM_TIMERS];
  logic [15:0] target_value [NUM_TIMERS];
  logic [16:0] tick_remainder [NUM_TIMERS];
  logic        oneshot_done [NUM_TIMERS];
  logic [2:0]  irq_acc;

  div_req_t dreq;
  div_rsp_t drsp;

  logic        accept;
  logic [1:0]  idx;
  logic        idx_ok;
  logic [15:0] cur_mode;
  logic [15:0] cur_alt;
  logic [16:0] sum;
  logic        use_alt;
  logic [17:0] total;
  logic [15:0] new_mode;
  logic        new_os;
  logic        new_irq;
  irq_upd_t    upd;

  function automatic irq_upd_t raise_irq(input logic [15:0] m, input logic od);
    irq_upd_t r;
    r.mode = m;
    r.oneshot = od;
    r.irq = 1'b0;
    if (m[MB_REPEAT] || !od) begin
      if (m[MB_TOGGLE]) begin
        r.mode[MB_REQUEST] = ~m[MB_REQUEST];
        r.irq = m[MB_REQUEST];
      end else begin
        r.mode[MB_REQUEST] = 1'b1;
        r.irq = 1'b1;
      end
      if (r.irq && !m[MB_REPEAT]) begin
        r.oneshot = 1'b1;
      end
    end
    return r;
  endfunction

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign pready = 1'b1;

  // single read port into the timer state: sequencer timer when busy
  assign idx    = busy ? tsel : request.reg_address[5:4];
  assign idx_ok = (idx != 2'd3);

  always_comb begin
    cur_mode = idx_ok ? mode_word[idx] : MODE_RESET;
    cur_alt  = idx_ok ? alt_rate[idx] : ALT_RESET;
    if (cur_alt < MIN_ALT_RATE) begin
      cur_alt = MIN_ALT_RATE;
    end
    use_alt = (idx == 2'd2) ? cur_mode[MB_SRC2] : cur_mode[MB_SRC01];
    sum = (idx_ok ? tick_remainder[idx] : 17'd0) + {1'b0, ticks};

    dreq.start = (state == ST_LOAD);
    dreq.num_a = use_alt ? {sum, 8'd0} : {7'd0, sum, 1'b0};
    dreq.den_a = use_alt ? cur_alt : 16'd3;
    dreq.num_b = {8'd0, sum};
    dreq.den_b = {8'd0, cur_alt[15:8]};
  end

  // target check first; its reset to zero feeds the bound check
  always_comb begin
    total    = {2'd0, (idx_ok ? count_value[idx] : 16'd0)} + {1'b0, drsp.quo_a[16:0]};
    new_mode = cur_mode;
    new_os   = idx_ok ? oneshot_done[idx] : 1'b0;
    new_irq  = 1'b0;
    upd      = '0;
    if (total >= {2'd0, (idx_ok ? target_value[idx] : 16'd0)}) begin
      if (new_mode[MB_RST_TGT]) begin
        total = '0;
      end
      new_mode[MB_HIT_TGT] = 1'b1;
      if (new_mode[MB_IRQ_TGT]) begin
        upd = raise_irq(new_mode, new_os);
        new_mode = upd.mode;
        new_os = upd.oneshot;
        new_irq = upd.irq;
      end
    end
    if (total >= BOUND_VALUE) begin
      if (!new_mode[MB_RST_TGT]) begin
        total = '0;
      end
      new_mode[MB_HIT_BND] = 1'b1;
      if (new_mode[MB_IRQ_BND]) begin
        upd = raise_irq(new_mode, new_os);
        new_mode = upd.mode;
        new_os = upd.oneshot;
        new_irq = new_irq || upd.irq;
      end
    end
  end

  tcrc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tsel  <= '0;
      ticks <= '0;
      done  <= 1'b0;
      irq_acc <= '0;
      result <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        alt_rate[i]       <= ALT_RESET;
        count_value[i]    <= '0;
        mode_word[i]      <= MODE_RESET;
        target_value[i]   <= '0;
        tick_remainder[i] <= '0;
        oneshot_done[i]   <= 1'b0;
      end
    end else begin
      done <= 1'b0;
      if (psel && penable && pwrite) begin
        unique case (paddr[3:2])
          CFG_ALT0: alt_rate[0] <= pwdata[15:0];
          CFG_ALT1: alt_rate[1] <= pwdata[15:0];
          CFG_ALT2: alt_rate[2] <= pwdata[15:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            result <= '0;
            tsel <= '0;
            irq_acc <= '0;
            ticks <= request.tick_count;
            if (request.cmd == CMD_ADVANCE) begin
              state <= ST_LOAD;
            end else begin
              done <= 1'b1;
              if (idx_ok && request.cmd == CMD_WRITE) begin
                unique case (request.reg_address[3:0])
                  OFF_COUNT: count_value[idx] <= request.write_value;
                  OFF_MODE: begin
                    mode_word[idx] <= request.write_value | MODE_RESET;
                    count_value[idx] <= '0;
                    oneshot_done[idx] <= 1'b0;
                  end
                  OFF_TARGET: target_value[idx] <= request.write_value;
                  default: ;
                endcase
              end else if (idx_ok && request.cmd == CMD_READ) begin
                unique case (request.reg_address[3:0])
                  OFF_COUNT: result.read_value <= count_value[idx];
                  OFF_MODE: begin
                    result.read_value <= cur_mode;
                    mode_word[idx][MB_HIT_TGT] <= 1'b0;
                    mode_word[idx][MB_HIT_BND] <= 1'b0;
                  end
                  OFF_TARGET: result.read_value <= target_value[idx];
                  default: ;
                endcase
              end
            end
          end
        end
        ST_LOAD: state <= ST_WAIT;
        ST_WAIT: begin
          if (drsp.valid) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          count_value[idx]    <= total[15:0];
          mode_word[idx]      <= new_mode;
          oneshot_done[idx]   <= new_os;
          tick_remainder[idx] <= use_alt ? {1'b0, drsp.rem_b} : 17'd0;
          irq_acc[idx]        <= new_irq;
          if (tsel == 2'd2) begin
            state <= ST_IDLE;
            done <= 1'b1;
            result.read_value <= '0;
            result.irq_raised <= {new_irq, irq_acc[1:0]};
          end else begin
            tsel <= tsel + 1'b1;
            state <= ST_LOAD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      CFG_ALT0: prdata = {16'd0, alt_rate[0]};
      CFG_ALT1: prdata = {16'd0, alt_rate[1]};
      CFG_ALT2: prdata = {16'd0, alt_rate[2]};
      default: prdata = '0;
    endcase
  end

  a_start_in_load: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> state == ST_LOAD)
    else $error("divider started outside load state");

  a_div_valid_wait: assert property (@(posedge clk) disable iff (rst)
    drsp.valid |-> state == ST_WAIT)
    else $error("divider result outside wait state");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_APPLY) || $past(accept))
    else $error("result without transaction");

  a_irq_only_advance: assert property (@(posedge clk) disable iff (rst)
    (done && result.irq_raised != 3'd0) |-> $past(state == ST_APPLY))
    else $error("interrupt flags on a register access");

endmodule
